// ----- rtl/core/tsrp_pkg.sv -----
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: shared package
// Widths, limits, codes, configuration record and controller handshake types.
// ----------------------------------------------------------------------------
package tsrp_pkg;

   // Timer and ramp limits
   localparam int unsigned TIMER_CLOCK_HZ  = 1000000;
   localparam int unsigned FASTEST_PERIOD  = 50;
   localparam int unsigned SLOWEST_PERIOD  = 5000;
   localparam int unsigned LOW_SPEED_LIMIT = 100;

   // Field widths
   localparam int unsigned RATE_W   = 21;
   localparam int unsigned SPEED_W  = 20;
   localparam int unsigned POS_W    = 32;
   localparam int unsigned STEP_W   = 16;
   localparam int unsigned PERIOD_W = 16;

   localparam int unsigned RATE_MAX    = (2 ** RATE_W) - 1;
   localparam int unsigned ACCEL_LIMIT = TIMER_CLOCK_HZ / FASTEST_PERIOD;
   localparam int unsigned DECEL_LIMIT = TIMER_CLOCK_HZ / SLOWEST_PERIOD;

   // Period divider: (2*clock + rate) / (2*rate), one quotient bit per cycle
   localparam int unsigned TWO_CLOCK = 2 * TIMER_CLOCK_HZ;
   localparam int unsigned DIV_W     = RATE_W + 1;
   localparam int unsigned NUM_W     = $clog2(TWO_CLOCK + RATE_MAX + 1);
   localparam int unsigned CNT_W     = $clog2(NUM_W);

   // Register file
   localparam int unsigned CSR_COUNT  = 7;
   localparam int unsigned CSR_ADDR_W = $clog2(CSR_COUNT) + 2;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_DIRECTION    = 3'd0,
      CSR_TARGET_POS   = 3'd1,
      CSR_TARGET_SPEED = 3'd2,
      CSR_ACCEL_END    = 3'd3,
      CSR_DECEL_START  = 3'd4,
      CSR_ACCEL_STEP   = 3'd5,
      CSR_DECEL_STEP   = 3'd6
   } tsrp_csr_index_type;

   typedef enum logic [1:0] {
      REQ_TICK      = 2'd0,
      REQ_START     = 2'd1,
      REQ_EXT_STOP  = 2'd2,
      REQ_SLOW_STOP = 2'd3
   } tsrp_req_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_CONST = 2'd2,
      PH_DECEL = 2'd3
   } tsrp_phase_type;

   typedef enum logic [1:0] {
      STOP_NONE     = 2'd0,
      STOP_TARGET   = 2'd1,
      STOP_EXTERNAL = 2'd2,
      STOP_SLOW     = 2'd3
   } tsrp_stop_type;

   typedef struct packed {
      logic                      direction_backward;
      logic signed [POS_W-1:0]   target_position;
      logic [SPEED_W-1:0]        target_speed;
      logic signed [POS_W-1:0]   accel_end_point;
      logic signed [POS_W-1:0]   decel_start_point;
      logic [STEP_W-1:0]         accel_step;
      logic [STEP_W-1:0]         decel_step;
   } tsrp_cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic out_load;
   } tsrp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_last;
   } tsrp_sts_type;

   // A position is past a mark when it has reached it in the direction of travel.
   function automatic logic tsrp_past(input logic backward,
                                      input logic signed [POS_W-1:0] pos,
                                      input logic signed [POS_W-1:0] mark);
      tsrp_past = backward ? (pos <= mark) : (pos >= mark);
   endfunction

endpackage

// ----- rtl/core/tsrp_req_if.sv -----
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface tsrp_req_if;
   import tsrp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic [SPEED_W-1:0]      start_rate;
   logic signed [POS_W-1:0] position_steps;
   logic signed [POS_W-1:0] position_um;
   logic [SPEED_W-1:0]      measured_speed;

   modport source (
      output valid, req_type, start_rate, position_steps, position_um, measured_speed,
      input  ready
   );

   modport sink (
      input  valid, req_type, start_rate, position_steps, position_um, measured_speed,
      output ready
   );

endinterface

// ----- rtl/core/tsrp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface tsrp_rsp_if;
   import tsrp_pkg::*;

   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] period;
   logic                period_written;
   logic                pulses_on;
   logic [1:0]          phase;
   logic [1:0]          stop_cause;

   modport source (
      output valid, period, period_written, pulses_on, phase, stop_cause,
      input  ready
   );

   modport sink (
      input  valid, period, period_written, pulses_on, phase, stop_cause,
      output ready
   );

endinterface

// ----- rtl/core/trapezoid_step_rate_profile.sv -----
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile generator
// One-axis stepper ramp: accelerate, constant, decelerate, stop at target.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one request transaction: a profile tick, a move start, an
//   external stop or a slow-stop tick, with the current axis position and the
//   measured speed. Every request gives exactly one result transaction on
//   rsp_if: the timer period for the new step rate, whether it changed, the
//   phase and the stop cause.
//   The APB-style port sets direction, target, ramp points and ramp steps;
//   the user writes it only while no request is outstanding, and the block
//   itself does not enforce this. The serial period divider gives one
//   quotient bit per cycle, and one request is handled at a time: a new
//   request is taken only once the previous result has been loaded into
//   the output register.
//   The result sits in an output register: a new request is accepted while
//   an earlier result waits, but that request's result is held back until
//   the receiver has taken the earlier one.
//   Synchronous reset returns the axis to idle with a step rate of one and
//   the registers to their reset values.
// ----------------------------------------------------------------------------
module trapezoid_step_rate_profile (
   input  logic                             clock,
   input  logic                             reset,
   tsrp_req_if.sink                         req_if,
   tsrp_rsp_if.source                       rsp_if,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tsrp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tsrp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tsrp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import tsrp_pkg::*;

   tsrp_cfg_type cfg;
   tsrp_cmd_type cmd;
   tsrp_sts_type sts;

   tsrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tsrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tsrp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .cfg                (cfg),
      .in_req_type        (req_if.req_type),
      .in_start_rate      (req_if.start_rate),
      .in_position_steps  (req_if.position_steps),
      .in_position_um     (req_if.position_um),
      .in_measured_speed  (req_if.measured_speed),
      .out_period         (rsp_if.period),
      .out_period_written (rsp_if.period_written),
      .out_pulses_on      (rsp_if.pulses_on),
      .out_phase          (rsp_if.phase),
      .out_stop_cause     (rsp_if.stop_cause)
   );

`ifndef SYNTHESIS
   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while another was in flight");

   // The saturated period never reaches zero.
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.period != '0))
      else $error("period of zero delivered");

   // Pulses run exactly while the axis is not idle.
   a_pulses_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.pulses_on == (rsp_if.phase != PH_IDLE)))
      else $error("pulses_on disagrees with phase");

   // Any stop leaves the axis idle.
   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.stop_cause != STOP_NONE)) |-> (rsp_if.phase == PH_IDLE))
      else $error("stop reported while axis still moving");
`endif

endmodule

// ----- rtl/core/tsrp_csr.sv -----
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: register file
// APB-style configuration registers with zero wait states.
// ----------------------------------------------------------------------------
module tsrp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsrp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [tsrp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [tsrp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output tsrp_pkg::tsrp_cfg_type             cfg
);
   import tsrp_pkg::*;

   tsrp_cfg_type       cfg_ff;
   tsrp_cfg_type       cfg_in;
   tsrp_csr_index_type csr_index;
   logic               wr_en;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign csr_index = tsrp_csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_DIRECTION:    cfg_in.direction_backward = pwdata[0];
            CSR_TARGET_POS:   cfg_in.target_position    = pwdata[POS_W-1:0];
            CSR_TARGET_SPEED: cfg_in.target_speed       = pwdata[SPEED_W-1:0];
            CSR_ACCEL_END:    cfg_in.accel_end_point    = pwdata[POS_W-1:0];
            CSR_DECEL_START:  cfg_in.decel_start_point  = pwdata[POS_W-1:0];
            CSR_ACCEL_STEP:   cfg_in.accel_step         = pwdata[STEP_W-1:0];
            CSR_DECEL_STEP:   cfg_in.decel_step         = pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction_backward <= 1'b0;
         cfg_ff.target_position    <= '0;
         cfg_ff.target_speed       <= '0;
         cfg_ff.accel_end_point    <= '0;
         cfg_ff.decel_start_point  <= '0;
         cfg_ff.accel_step         <= STEP_W'(1);
         cfg_ff.decel_step         <= STEP_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DIRECTION:    prdata = CSR_DATA_W'(cfg_ff.direction_backward);
         CSR_TARGET_POS:   prdata = cfg_ff.target_position;
         CSR_TARGET_SPEED: prdata = CSR_DATA_W'(cfg_ff.target_speed);
         CSR_ACCEL_END:    prdata = cfg_ff.accel_end_point;
         CSR_DECEL_START:  prdata = cfg_ff.decel_start_point;
         CSR_ACCEL_STEP:   prdata = CSR_DATA_W'(cfg_ff.accel_step);
         CSR_DECEL_STEP:   prdata = CSR_DATA_W'(cfg_ff.decel_step);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/tsrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: controller
// Sequences capture, profile update, period division and result hand-off.
// ----------------------------------------------------------------------------
module tsrp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tsrp_pkg::tsrp_cmd_type cmd,
   input  tsrp_pkg::tsrp_sts_type sts
);
   import tsrp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_UPDATE  = 4'b0010,
      ST_DIVIDE  = 4'b0100,
      ST_DELIVER = 4'b1000
   } tsrp_state_type;

   tsrp_state_type state_ff;
   tsrp_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   // The output register is free when empty or being taken in this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/tsrp_datapath.sv -----
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: datapath
// Phase and rate update, serial period divider and output register.
// ----------------------------------------------------------------------------
module tsrp_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tsrp_pkg::tsrp_cmd_type               cmd,
   output tsrp_pkg::tsrp_sts_type               sts,
   input  tsrp_pkg::tsrp_cfg_type               cfg,
   input  logic [1:0]                           in_req_type,
   input  logic [tsrp_pkg::SPEED_W-1:0]         in_start_rate,
   input  logic signed [tsrp_pkg::POS_W-1:0]    in_position_steps,
   input  logic signed [tsrp_pkg::POS_W-1:0]    in_position_um,
   input  logic [tsrp_pkg::SPEED_W-1:0]         in_measured_speed,
   output logic [tsrp_pkg::PERIOD_W-1:0]        out_period,
   output logic                                 out_period_written,
   output logic                                 out_pulses_on,
   output logic [1:0]                           out_phase,
   output logic [1:0]                           out_stop_cause
);
   import tsrp_pkg::*;

   // Captured request
   tsrp_req_kind_type       kind_ff;
   logic [SPEED_W-1:0]      start_rate_ff;
   logic signed [POS_W-1:0] pos_steps_ff;
   logic signed [POS_W-1:0] pos_um_ff;
   logic [SPEED_W-1:0]      meas_ff;

   // Profile state
   tsrp_phase_type          phase_ff;
   tsrp_phase_type          phase_in;
   logic [RATE_W-1:0]       rate_ff;
   logic [RATE_W-1:0]       rate_in;
   logic                    written_ff;
   logic                    written_in;
   tsrp_stop_type           cause_ff;
   tsrp_stop_type           cause_in;

   // Divider
   logic [DIV_W-1:0]        den_ff;
   logic [DIV_W-1:0]        den_in;
   logic [DIV_W-1:0]        rem_ff;
   logic [DIV_W-1:0]        rem_in;
   logic [NUM_W-1:0]        quo_ff;
   logic [NUM_W-1:0]        quo_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;

   // Output register
   logic [PERIOD_W-1:0]     period_ff;
   logic                    out_written_ff;
   tsrp_phase_type          out_phase_ff;
   tsrp_stop_type           out_cause_ff;

   logic                    accel_ok;
   logic                    decel_ok;
   logic [RATE_W:0]         rate_sum;
   logic [RATE_W-1:0]       rate_acc;
   logic [RATE_W-1:0]       rate_dec;
   logic                    meas_low;
   logic                    past_accel;
   logic                    past_decel;
   logic                    past_target;
   logic [RATE_W-1:0]       div_rate;
   logic [DIV_W:0]          rem_shift;
   logic                    quo_bit;
   logic [PERIOD_W-1:0]     period_sat;

   // Ramp arithmetic on the stored rate
   assign accel_ok = 32'(rate_ff) <= ACCEL_LIMIT;
   assign decel_ok = 32'(rate_ff) >= DECEL_LIMIT;
   assign rate_sum = (RATE_W + 1)'(rate_ff) + (RATE_W + 1)'(cfg.accel_step);
   assign rate_acc = rate_sum[RATE_W] ? RATE_W'(RATE_MAX) : rate_sum[RATE_W-1:0];
   assign rate_dec = (rate_ff > RATE_W'(cfg.decel_step)) ?
                     (rate_ff - RATE_W'(cfg.decel_step)) : '0;
   assign meas_low    = 32'(meas_ff) <= LOW_SPEED_LIMIT;
   assign past_accel  = tsrp_past(cfg.direction_backward, pos_steps_ff, cfg.accel_end_point);
   assign past_decel  = tsrp_past(cfg.direction_backward, pos_steps_ff, cfg.decel_start_point);
   assign past_target = tsrp_past(cfg.direction_backward, pos_um_ff, cfg.target_position);

   // Profile update. A phase entered during a tick is handled in the same tick.
   always_comb begin
      phase_in   = phase_ff;
      rate_in    = rate_ff;
      written_in = written_ff;
      cause_in   = cause_ff;
      if (cmd.update) begin
         written_in = 1'b0;
         cause_in   = STOP_NONE;
         case (kind_ff)
            REQ_START: begin
               rate_in    = RATE_W'(start_rate_ff);
               phase_in   = PH_ACCEL;
               written_in = 1'b1;
            end
            REQ_EXT_STOP: begin
               phase_in = PH_IDLE;
               cause_in = STOP_EXTERNAL;
            end
            REQ_SLOW_STOP: begin
               if (phase_ff != PH_IDLE) begin
                  if (meas_low) begin
                     phase_in = PH_IDLE;
                     cause_in = STOP_SLOW;
                  end else begin
                     phase_in = PH_DECEL;
                     if (decel_ok) begin
                        rate_in    = rate_dec;
                        written_in = 1'b1;
                     end
                  end
               end
            end
            REQ_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (phase_ff == PH_ACCEL) begin
                     if ((meas_ff >= cfg.target_speed) || past_accel) begin
                        phase_in = PH_CONST;
                     end else if (accel_ok) begin
                        rate_in    = rate_acc;
                        written_in = 1'b1;
                     end
                  end
                  if (past_target) begin
                     phase_in = PH_IDLE;
                     cause_in = STOP_TARGET;
                  end else begin
                     if ((phase_in == PH_CONST) && past_decel) begin
                        phase_in = PH_DECEL;
                     end
                     // Reached only when the rate was not raised in this tick.
                     if ((phase_in == PH_DECEL) && decel_ok) begin
                        rate_in    = rate_dec;
                        written_in = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Restoring division of (2*clock + rate) by 2*rate, rate taken as at least 1.
   assign div_rate  = (rate_in == '0) ? RATE_W'(1) : rate_in;
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign quo_bit   = rem_shift >= {1'b0, den_ff};

   always_comb begin
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.update) begin
         den_in = {div_rate, 1'b0};
         rem_in = '0;
         quo_in = NUM_W'(TWO_CLOCK) + NUM_W'(div_rate);
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = quo_bit ? DIV_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DIV_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], quo_bit};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign sts.div_last = (cnt_ff == CNT_W'(NUM_W - 1));

   always_comb begin
      if (|quo_ff[NUM_W-1:PERIOD_W]) begin
         period_sat = '1;
      end else if (quo_ff[PERIOD_W-1:0] == '0) begin
         period_sat = PERIOD_W'(1);
      end else begin
         period_sat = quo_ff[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rate_ff  <= RATE_W'(1);
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         rate_ff  <= rate_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      written_ff <= written_in;
      cause_ff   <= cause_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      if (cmd.capture) begin
         kind_ff       <= tsrp_req_kind_type'(in_req_type);
         start_rate_ff <= in_start_rate;
         pos_steps_ff  <= in_position_steps;
         pos_um_ff     <= in_position_um;
         meas_ff       <= in_measured_speed;
      end
      if (cmd.out_load) begin
         period_ff      <= period_sat;
         out_written_ff <= written_ff;
         out_phase_ff   <= phase_ff;
         out_cause_ff   <= cause_ff;
      end
   end

   assign out_period         = period_ff;
   assign out_period_written = out_written_ff;
   assign out_pulses_on      = (out_phase_ff != PH_IDLE);
   assign out_phase          = out_phase_ff;
   assign out_stop_cause     = out_cause_ff;

endmodule

// ----- dv/tsrp_profile_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: result checker
// Follows register writes and request transactions, predicts each result of
// the ramp generator and compares it field by field with what the block gives.
// ----------------------------------------------------------------------------
module tsrp_profile_checker (
   input  logic                            clock,
   input  logic                            reset,
   tsrp_req_if                             req_if,
   tsrp_rsp_if                             rsp_if,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tsrp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tsrp_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                            pready,
   output int                              pending,
   output int                              failures
);
   import tsrp_pkg::*;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                written;
      logic                pulses_on;
      tsrp_phase_type      phase;
      tsrp_stop_type       stop_cause;
   } ramp_result_type;

   tsrp_cfg_type      cfg;
   tsrp_phase_type    axis_phase;
   logic [RATE_W-1:0] axis_rate;
   ramp_result_type   expected_results[$];
   int                mismatches = 0;

   function automatic logic [PERIOD_W-1:0] timer_period(logic [RATE_W-1:0] rate);
      longint unsigned divisor, quotient;
      divisor  = (rate == '0) ? 64'd1 : 64'(rate);
      quotient = (64'd2 * TIMER_CLOCK_HZ + divisor) / (64'd2 * divisor);
      if (quotient > 64'd65535) quotient = 64'd65535;
      if (quotient < 64'd1) quotient = 64'd1;
      return quotient[PERIOD_W-1:0];
   endfunction

   // "Beyond" follows the direction of travel: reached or overtaken.
   function automatic logic beyond(logic signed [POS_W-1:0] pos, logic signed [POS_W-1:0] mark);
      return cfg.direction_backward ? (pos <= mark) : (pos >= mark);
   endfunction

   function automatic logic ramp_up();
      logic [RATE_W:0] sum;
      if (axis_rate <= ACCEL_LIMIT) begin
         sum = (RATE_W + 1)'(axis_rate) + (RATE_W + 1)'(cfg.accel_step);
         axis_rate = (sum > RATE_MAX) ? RATE_MAX[RATE_W-1:0] : sum[RATE_W-1:0];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic ramp_down();
      if (axis_rate >= DECEL_LIMIT) begin
         axis_rate = (axis_rate > cfg.decel_step) ? axis_rate - cfg.decel_step : '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic ramp_result_type advance_profile(tsrp_req_kind_type kind,
                                                       logic [SPEED_W-1:0] start_rate,
                                                       logic signed [POS_W-1:0] steps_pos,
                                                       logic signed [POS_W-1:0] um_pos,
                                                       logic [SPEED_W-1:0] speed);
      ramp_result_type res;
      logic            written;
      tsrp_stop_type   cause;
      written = 1'b0;
      cause   = STOP_NONE;
      case (kind)
         REQ_START: begin
            axis_rate  = RATE_W'(start_rate);
            axis_phase = PH_ACCEL;
            written    = 1'b1;
         end
         REQ_EXT_STOP: begin
            axis_phase = PH_IDLE;
            cause      = STOP_EXTERNAL;
         end
         REQ_SLOW_STOP: begin
            if (axis_phase != PH_IDLE) begin
               if (speed <= LOW_SPEED_LIMIT) begin
                  axis_phase = PH_IDLE;
                  cause      = STOP_SLOW;
               end else begin
                  axis_phase = PH_DECEL;
                  written    = ramp_down();
               end
            end
         end
         REQ_TICK: begin
            if (axis_phase != PH_IDLE) begin
               if (axis_phase == PH_ACCEL) begin
                  if (speed >= cfg.target_speed || beyond(steps_pos, cfg.accel_end_point))
                     axis_phase = PH_CONST;
                  else
                     written = ramp_up();
               end
               // Reaching the target ends the move before any deceleration step.
               if (beyond(um_pos, cfg.target_position)) begin
                  axis_phase = PH_IDLE;
                  cause      = STOP_TARGET;
               end else begin
                  if (axis_phase == PH_CONST && beyond(steps_pos, cfg.decel_start_point))
                     axis_phase = PH_DECEL;
                  if (axis_phase == PH_DECEL && ramp_down())
                     written = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.period     = timer_period(axis_rate);
      res.written    = written;
      res.pulses_on  = (axis_phase != PH_IDLE);
      res.phase      = axis_phase;
      res.stop_cause = cause;
      return res;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      ramp_result_type want;
      if (reset) begin
         cfg.direction_backward = 1'b0;
         cfg.target_position    = '0;
         cfg.target_speed       = '0;
         cfg.accel_end_point    = '0;
         cfg.decel_start_point  = '0;
         cfg.accel_step         = 16'd1;
         cfg.decel_step         = 16'd1;
         axis_phase             = PH_IDLE;
         axis_rate              = 1;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (tsrp_csr_index_type'(paddr[CSR_ADDR_W-1:2]))
               CSR_DIRECTION:    cfg.direction_backward = pwdata[0];
               CSR_TARGET_POS:   cfg.target_position    = pwdata;
               CSR_TARGET_SPEED: cfg.target_speed       = pwdata[SPEED_W-1:0];
               CSR_ACCEL_END:    cfg.accel_end_point    = pwdata;
               CSR_DECEL_START:  cfg.decel_start_point  = pwdata;
               CSR_ACCEL_STEP:   cfg.accel_step         = pwdata[STEP_W-1:0];
               CSR_DECEL_STEP:   cfg.decel_step         = pwdata[STEP_W-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            expected_results.push_back(advance_profile(tsrp_req_kind_type'(req_if.req_type),
                                                       req_if.start_rate,
                                                       req_if.position_steps,
                                                       req_if.position_um,
                                                       req_if.measured_speed));
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with nothing expected: period %0d, phase %0d",
                      rsp_if.period, rsp_if.phase);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               compare_field("period", want.period, rsp_if.period);
               compare_field("period_written", want.written, rsp_if.period_written);
               compare_field("pulses_on", want.pulses_on, rsp_if.pulses_on);
               compare_field("phase", want.phase, rsp_if.phase);
               compare_field("stop_cause", want.stop_cause, rsp_if.stop_cause);
            end
         end
      end
      pending  <= expected_results.size();
      failures <= mismatches;
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trapezoid step-rate profile: testbench top
// Drives directed and random move sequences, register settings and random
// back-pressure into the ramp generator; the checker beside it predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import tsrp_pkg::*;

   localparam int unsigned SPEED_MAX  = (1 << SPEED_W) - 1;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam int ITEM_GOAL  = 500;
   localparam int QUIET_FROM = 440;
   localparam int HOLD_AT    = 150;
   localparam int HOLD_SPAN  = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;
   int                    pending, failures;

   int     useful     = 0;
   bit     quiet      = 1'b0;
   bit     send_gaps  = 1'b1;
   bit     backward;
   int     heading;
   int     move_span;
   longint move_origin, um_origin;

   tsrp_req_if req_if ();
   tsrp_rsp_if rsp_if ();

   trapezoid_step_rate_profile u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tsrp_profile_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .pready   (pready),
      .pending  (pending),
      .failures (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("trapezoid_step_rate_profile: mismatch");
      $finish;
   end

   // Valid stays high from one transaction to the next unless a gap is drawn.
   task automatic send_request(tsrp_req_kind_type kind, logic [SPEED_W-1:0] rate,
                               logic signed [POS_W-1:0] steps_pos,
                               logic signed [POS_W-1:0] um_pos,
                               logic [SPEED_W-1:0] speed);
      if (useful >= QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(0, 39) == 0) send_gaps = !send_gaps;
      if (!quiet && send_gaps && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.req_type       <= kind;
      req_if.start_rate     <= rate;
      req_if.position_steps <= steps_pos;
      req_if.position_um    <= um_pos;
      req_if.measured_speed <= speed;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Every request yields one result, so an empty expectation store means the
   // block is idle; the extra cycles cover the lag of the pending count.
   task automatic wait_for_idle_axis();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(tsrp_csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_profile(bit dir, logic signed [POS_W-1:0] goal,
                               logic [SPEED_W-1:0] top_speed,
                               logic signed [POS_W-1:0] acc_mark,
                               logic signed [POS_W-1:0] dec_mark,
                               logic [STEP_W-1:0] up_step, logic [STEP_W-1:0] down_step);
      write_register(CSR_DIRECTION, 32'(dir));
      write_register(CSR_TARGET_POS, goal);
      write_register(CSR_TARGET_SPEED, 32'(top_speed));
      write_register(CSR_ACCEL_END, acc_mark);
      write_register(CSR_DECEL_START, dec_mark);
      write_register(CSR_ACCEL_STEP, 32'(up_step));
      write_register(CSR_DECEL_STEP, 32'(down_step));
   endtask

   function automatic logic signed [POS_W-1:0] steps_at(longint travel);
      return POS_W'(move_origin + heading * travel);
   endfunction

   function automatic logic signed [POS_W-1:0] um_at(longint travel);
      return POS_W'(um_origin + heading * 3 * travel);
   endfunction

   function automatic logic [SPEED_W-1:0] pick_start_rate();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return SPEED_MAX;
      if (roll < 3) return $urandom_range(1, SPEED_MAX);
      return $urandom_range(1, 5000);
   endfunction

   // Chooses a move geometry and programs matching ramp points; now and then
   // the registers take extreme or arbitrary values instead.
   task automatic program_profile();
      logic signed [POS_W-1:0] goal, acc_mark, dec_mark;
      logic [SPEED_W-1:0]      top_speed;
      logic [STEP_W-1:0]       up_step, down_step;
      int                      pick, acc_pct, dec_pct;
      pick      = $urandom_range(0, 5);
      backward  = $urandom_range(0, 1);
      heading   = backward ? -1 : 1;
      move_span = $urandom_range(20, 4000);
      if (pick == 0) begin
         move_origin = backward ? longint'(POS_MAX) - int'($urandom_range(0, 50))
                                : longint'(POS_MIN) + int'($urandom_range(0, 50));
         um_origin   = backward ? longint'(POS_MAX) - int'($urandom_range(0, 50))
                                : longint'(POS_MIN) + int'($urandom_range(0, 50));
      end else begin
         move_origin = longint'($urandom_range(0, 2000000)) - 1000000;
         um_origin   = longint'($urandom_range(0, 6000000)) - 3000000;
      end
      acc_pct   = $urandom_range(0, 60);
      dec_pct   = $urandom_range(30, 100);
      goal      = um_at(move_span);
      acc_mark  = steps_at(move_span * acc_pct / 100);
      dec_mark  = steps_at(move_span * dec_pct / 100);
      top_speed = $urandom_range(500, 40000);
      up_step   = $urandom_range(1, 3000);
      down_step = $urandom_range(1, 3000);
      if (pick == 1) begin
         top_speed = $urandom_range(0, 1) ? '0 : '1;
         up_step   = $urandom_range(0, 1) ? '0 : '1;
         down_step = $urandom_range(0, 1) ? '0 : '1;
         goal      = $urandom;
         acc_mark  = $urandom;
         dec_mark  = $urandom;
      end
      load_profile(backward, goal, top_speed, acc_mark, dec_mark, up_step, down_step);
   endtask

   task automatic slow_down(longint travel, int speed);
      do begin
         speed = speed / 2 - int'($urandom_range(0, 50));
         if (speed < 0) speed = 0;
         send_request(REQ_SLOW_STOP, $urandom_range(1, SPEED_MAX), steps_at(travel),
                      um_at(travel), speed);
         useful++;
      end while (speed > LOW_SPEED_LIMIT);
   endtask

   // One move: a start, then ticks with the axis advancing towards the
   // target, sometimes cut short by a stop or restarted on the way.
   task automatic run_move();
      longint travel;
      int     speed, stride, roll;
      bit     done;
      travel = 0;
      done   = 1'b0;
      speed  = $urandom_range(0, 300);
      stride = move_span / int'($urandom_range(5, 30)) * 2 + 1;
      send_request(REQ_START, pick_start_rate(), steps_at(travel), um_at(travel), speed);
      useful++;
      while (!done) begin
         travel += int'($urandom_range(0, stride));
         speed  += int'($urandom_range(0, 2500));
         if (speed > int'(SPEED_MAX)) speed = SPEED_MAX;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send_request(REQ_EXT_STOP, $urandom_range(1, SPEED_MAX), steps_at(travel),
                         um_at(travel), speed);
            useful++;
            done = 1'b1;
         end else if (roll < 7) begin
            slow_down(travel, speed);
            done = 1'b1;
         end else begin
            send_request(roll < 10 ? REQ_START : REQ_TICK, pick_start_rate(),
                         steps_at(travel), um_at(travel), speed);
            useful++;
            if (travel >= move_span) done = 1'b1;
         end
      end
      // A tick after the axis has stopped should change nothing.
      if ($urandom_range(0, 3) == 0)
         send_request(REQ_TICK, $urandom_range(1, SPEED_MAX), steps_at(travel),
                      um_at(travel), speed);
   endtask

   // Receiver: short random stalls, one long hold-off, none at the end.
   initial begin
      bit stalls;
      bit held;
      stalls = 1'b1;
      held   = 1'b0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) == 0) stalls = !stalls;
         if (!held && useful >= HOLD_AT) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_SPAN) @(posedge clock);
         end else if (!quiet && stalls && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      req_if.valid          <= 1'b0;
      req_if.req_type       <= REQ_TICK;
      req_if.start_rate     <= '0;
      req_if.position_steps <= '0;
      req_if.position_um    <= '0;
      req_if.measured_speed <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Registers at their reset values: requests while idle, then a
      // slowest-rate move that hits the target at position zero.
      send_request(REQ_TICK, 1, 0, 0, 0);
      send_request(REQ_SLOW_STOP, 1, 0, 0, 0);
      send_request(REQ_EXT_STOP, 1, 0, 0, 0);
      send_request(REQ_START, 1, 0, 0, 0);
      send_request(REQ_TICK, 1, 0, -1, 0);
      send_request(REQ_TICK, 1, 0, 0, 0);

      // Forward with the marks at the top of the range and the largest steps.
      wait_for_idle_axis();
      load_profile(1'b0, POS_MAX, SPEED_MAX, POS_MAX, POS_MAX, '1, '1);
      send_request(REQ_START, 19000, POS_MIN, POS_MIN, 0);
      send_request(REQ_TICK, 1, POS_MIN, 0, 1000);
      // The rate is now above the acceleration limit, so nothing changes.
      send_request(REQ_TICK, 1, POS_MIN, 0, 1000);
      send_request(REQ_START, SPEED_MAX, POS_MAX, POS_MAX, 0);
      send_request(REQ_SLOW_STOP, 1, 0, 0, SPEED_MAX);
      send_request(REQ_START, 300, 0, 0, 0);
      // Accelerate falls through constant into decelerate; the rate floors at zero.
      send_request(REQ_TICK, 1, POS_MAX, 0, 0);
      send_request(REQ_TICK, 1, POS_MAX, 0, 0);
      send_request(REQ_SLOW_STOP, 1, 0, 0, LOW_SPEED_LIMIT);
      send_request(REQ_START, 5000, 0, 0, 0);
      send_request(REQ_EXT_STOP, 1, 0, 0, 0);

      // Backward with the marks at the bottom of the range and zero steps.
      wait_for_idle_axis();
      load_profile(1'b1, POS_MIN, 2000, POS_MIN, POS_MIN, '0, '0);
      send_request(REQ_START, 500, POS_MAX, POS_MAX, 0);
      send_request(REQ_TICK, 1, POS_MAX, POS_MAX, LOW_SPEED_LIMIT + 1);
      send_request(REQ_SLOW_STOP, 1, POS_MAX, POS_MAX, LOW_SPEED_LIMIT + 1);
      send_request(REQ_TICK, 1, 0, POS_MIN, 0);
      send_request(REQ_TICK, 1, 0, POS_MIN, 0);

      while (useful < ITEM_GOAL) begin
         wait_for_idle_axis();
         program_profile();
         repeat ($urandom_range(1, 3)) run_move();
         repeat ($urandom_range(0, 4))
            send_request(tsrp_req_kind_type'(2'($urandom_range(0, 3))),
                         $urandom_range(1, SPEED_MAX), $urandom, $urandom,
                         $urandom_range(0, SPEED_MAX));
      end

      wait_for_idle_axis();
      repeat (60) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("trapezoid_step_rate_profile: match");
      end else begin
         $display("trapezoid_step_rate_profile: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/tsrp_pkg.sv
rtl/core/tsrp_req_if.sv
rtl/core/tsrp_rsp_if.sv
rtl/core/tsrp_csr.sv
rtl/core/tsrp_ctrl.sv
rtl/core/tsrp_datapath.sv
rtl/core/trapezoid_step_rate_profile.sv
dv/tsrp_profile_checker.sv
dv/testbench.sv
